FILE: hw/rtl/hmed_pkg.sv
// Shared types, character constants and matcher functions for the message end detector.
`default_nettype none
package hmed_pkg;

  localparam logic [7:0] CR = 8'h0D;
  localparam logic [7:0] LF = 8'h0A;
  localparam int unsigned KW_LEN = 15;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_message;
  } msg_beat_t;

  typedef struct packed {
    logic complete;
    logic in_body;
    logic length_overflow;
  } res_beat_t;

  // "Content-Length:"
  function automatic logic [7:0] kw_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h4C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  // Header end matcher: "\n\r\n" for requests, "\r\n\r\n" for responses. {hit, next_pos}
  function automatic logic [2:0] hdr_end_step(input logic [1:0] pos, input logic [7:0] b,
                                               input logic rsp);
    logic [1:0] p;
    logic [2:0] plen;
    logic [7:0] pc;
    logic [7:0] p0;
    logic [2:0] r;
    plen = rsp ? 3'd4 : 3'd3;
    p = pos;
    if ({1'b0, pos} >= plen) begin
      p = 2'd0;
    end
    p0 = rsp ? CR : LF;
    if (rsp) begin
      pc = p[0] ? LF : CR;
    end else begin
      pc = (p == 2'd1) ? CR : LF;
    end
    if (b == pc) begin
      if (({1'b0, p} + 3'd1) == plen) begin
        r = {1'b1, 2'd0};
      end else begin
        r = {1'b0, 2'(p + 2'd1)};
      end
    end else begin
      r = {1'b0, (b == p0) ? 2'd1 : 2'd0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/http_message_end_detector.sv
// Top level of the HTTP message end detector: input stage, parser, result stage, APB register.
//
//  channel  | direction | handshake          | beat
//  ---------+-----------+--------------------+-------------------------------------------
//  msg      | in        | msg_valid/msg_stall| data_byte, start_of_message
//  res      | out       | res_valid/res_stall| complete, in_body, length_overflow
//  apb      | in        | psel/penable/pready| message_mode at byte address 0
//
// One byte per cycle sustained while res_stall is low; a taken byte goes through the input
// register, then through the parse logic into the result register.
// Reset (rst, synchronous) clears both stages, the parse state and the mode register.
// res_stall holds the result register and, once the input stage is also full, msg_stall.
`default_nettype none
module http_message_end_detector #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                msg_valid,
  output logic                     msg_stall,
  input  wire hmed_pkg::msg_beat_t msg_beat,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output hmed_pkg::res_beat_t      res_beat,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import hmed_pkg::*;

  logic      s1_valid;
  msg_beat_t s1_beat;
  logic      out_free;
  logic      step;
  logic      message_mode;
  res_beat_t result;

  assign out_free  = !res_valid || !res_stall;
  assign step      = s1_valid && out_free;
  assign msg_stall = s1_valid && !out_free;

  hmed_apb u_apb (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .message_mode (message_mode)
  );

  hmed_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .beat         (s1_beat),
    .message_mode (message_mode),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!msg_stall) begin
      s1_valid <= msg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!msg_stall && msg_valid) begin
      s1_beat <= msg_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_beat <= result;
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    msg_stall |=> s1_valid && $stable(s1_beat))
    else $error("input stage lost a stalled beat");

  a_res_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_valid))
    else $error("result raised without a parsed beat");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_beat))
    else $error("stalled result beat changed");

endmodule
`default_nettype wire

FILE: hw/rtl/hmed_apb.sv
// APB register block holding the message mode.
`default_nettype none
module hmed_apb (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             message_mode
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      message_mode <= 1'b0;
    end else if (wr_en) begin
      message_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {31'd0, message_mode} : 32'd0;

endmodule
`default_nettype wire

FILE: hw/rtl/hmed_parse.sv
// Parse state and per-byte next-state logic for header, length and body tracking.
`default_nettype none
module hmed_parse #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire hmed_pkg::msg_beat_t beat,
  input  wire logic              message_mode,
  output hmed_pkg::res_beat_t    result
);
  import hmed_pkg::*;

  localparam int unsigned AccW = LENGTH_BITS + 4;
  localparam logic [LENGTH_BITS-1:0] LenMax = {LENGTH_BITS{1'b1}};

  typedef enum logic [7:0] {
    PH_SCAN    = 8'b0000_0001,
    PH_SKIP    = 8'b0000_0010,
    PH_DEC     = 8'b0000_0100,
    PH_TAIL    = 8'b0000_1000,
    PH_BODY    = 8'b0001_0000,
    PH_HEX     = 8'b0010_0000,
    PH_HEXTAIL = 8'b0100_0000,
    PH_SKIPLF  = 8'b1000_0000
  } phase_t;

  phase_t                 phase, phase_next, cur_phase;
  logic [3:0]             kw_pos, kw_pos_next, cur_kw_pos;
  logic [1:0]             he_pos, he_pos_next, cur_he_pos;
  logic                   line_start, line_start_next, cur_line_start;
  logic                   len_seen, len_seen_next, cur_len_seen;
  logic [LENGTH_BITS-1:0] decl_len, decl_len_next, cur_decl_len;
  logic [LENGTH_BITS-1:0] body_cnt, body_cnt_next, cur_body_cnt;
  logic                   ovf, ovf_next, cur_ovf;
  logic                   done, done_next, cur_done;

  logic [7:0]     b;
  logic           lf;
  logic           rsp;
  logic [4:0]     hexd;
  logic [2:0]     he_res;
  logic [AccW-1:0] acc_dec, acc_hex;
  logic           acc_dec_ovf, acc_hex_ovf;

  assign b   = beat.data_byte;
  assign lf  = (b == LF);
  assign rsp = message_mode;

  assign cur_phase      = beat.start_of_message ? PH_SCAN : phase;
  assign cur_kw_pos     = beat.start_of_message ? 4'd0 : kw_pos;
  assign cur_he_pos     = beat.start_of_message ? 2'd0 : he_pos;
  assign cur_line_start = beat.start_of_message ? 1'b1 : line_start;
  assign cur_len_seen   = beat.start_of_message ? 1'b0 : len_seen;
  assign cur_decl_len   = beat.start_of_message ? '0 : decl_len;
  assign cur_body_cnt   = beat.start_of_message ? '0 : body_cnt;
  assign cur_ovf        = beat.start_of_message ? 1'b0 : ovf;
  assign cur_done       = beat.start_of_message ? 1'b0 : done;

  assign hexd    = hex_digit(b);
  assign he_res  = hdr_end_step(cur_he_pos, b, rsp);
  assign acc_dec = (AccW'(cur_decl_len) << 3) + (AccW'(cur_decl_len) << 1) + AccW'(b[3:0]);
  assign acc_hex = (AccW'(cur_decl_len) << 4) + AccW'(hexd[3:0]);
  assign acc_dec_ovf = |acc_dec[AccW-1:LENGTH_BITS];
  assign acc_hex_ovf = |acc_hex[AccW-1:LENGTH_BITS];

  always_comb begin
    phase_next      = cur_phase;
    kw_pos_next     = cur_kw_pos;
    he_pos_next     = cur_he_pos;
    line_start_next = cur_line_start;
    len_seen_next   = cur_len_seen;
    decl_len_next   = cur_decl_len;
    body_cnt_next   = cur_body_cnt;
    ovf_next        = cur_ovf;
    done_next       = cur_done;
    if (!cur_done) begin
      case (cur_phase)
        PH_BODY: begin
          body_cnt_next = cur_body_cnt + LENGTH_BITS'(1);
          if (body_cnt_next == cur_decl_len) begin
            done_next = 1'b1;
          end
        end
        PH_HEX: begin
          if (b == CR) begin
            phase_next = PH_SKIPLF;
          end else if (hexd[4]) begin
            decl_len_next = acc_hex_ovf ? LenMax : acc_hex[LENGTH_BITS-1:0];
            ovf_next      = cur_ovf | acc_hex_ovf;
          end else begin
            phase_next = PH_HEXTAIL;
          end
        end
        PH_HEXTAIL: begin
          if (b == CR) begin
            phase_next = PH_SKIPLF;
          end
        end
        PH_SKIPLF: begin
          phase_next    = PH_BODY;
          body_cnt_next = '0;
          if (cur_decl_len == '0) begin
            done_next = 1'b1;
          end
        end
        default: begin
          case (cur_phase)
            PH_SCAN: begin
              if (!rsp) begin
                if (cur_line_start && b == kw_char(4'd0)) begin
                  kw_pos_next = 4'd1;
                end else if (cur_kw_pos != 4'd0 && cur_kw_pos < 4'(KW_LEN) &&
                             b == kw_char(cur_kw_pos)) begin
                  kw_pos_next = cur_kw_pos + 4'd1;
                end else begin
                  kw_pos_next = 4'd0;
                end
                if (kw_pos_next >= 4'(KW_LEN)) begin
                  kw_pos_next   = 4'd0;
                  len_seen_next = 1'b1;
                  decl_len_next = '0;
                  phase_next    = PH_SKIP;
                end
              end
            end
            PH_SKIP: begin
              phase_next = lf ? PH_SCAN : PH_DEC;
            end
            PH_DEC: begin
              if (b inside {[8'h30:8'h39]}) begin
                decl_len_next = acc_dec_ovf ? LenMax : acc_dec[LENGTH_BITS-1:0];
                ovf_next      = cur_ovf | acc_dec_ovf;
              end else begin
                phase_next = lf ? PH_SCAN : PH_TAIL;
              end
            end
            default: begin
              if (lf) begin
                phase_next = PH_SCAN;
              end
            end
          endcase
          line_start_next = lf;
          he_pos_next     = he_res[1:0];
          if (he_res[2]) begin
            kw_pos_next   = 4'd0;
            body_cnt_next = '0;
            if (rsp) begin
              decl_len_next = '0;
              phase_next    = PH_HEX;
            end else begin
              phase_next = PH_BODY;
              if (!len_seen_next || decl_len_next == '0) begin
                done_next = 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SCAN;
      kw_pos     <= 4'd0;
      he_pos     <= 2'd0;
      line_start <= 1'b1;
      len_seen   <= 1'b0;
      decl_len   <= '0;
      body_cnt   <= '0;
      ovf        <= 1'b0;
      done       <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      kw_pos     <= kw_pos_next;
      he_pos     <= he_pos_next;
      line_start <= line_start_next;
      len_seen   <= len_seen_next;
      decl_len   <= decl_len_next;
      body_cnt   <= body_cnt_next;
      ovf        <= ovf_next;
      done       <= done_next;
    end
  end

  assign result.complete        = done_next;
  assign result.in_body         = phase_next inside {PH_BODY, PH_HEX, PH_HEXTAIL, PH_SKIPLF};
  assign result.length_overflow = ovf_next;

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    step && !beat.start_of_message && done |=> done)
    else $error("complete dropped without a start beat");

  a_done_in_body: assert property (@(posedge clk) disable iff (rst)
    done |-> phase == PH_BODY)
    else $error("complete outside the body phase");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    step && !beat.start_of_message && ovf |=> ovf)
    else $error("length overflow dropped without a start beat");

endmodule
`default_nettype wire

FILE: tb/http_message_end_detector_tb.sv
// Self-checking bench for the HTTP message end detector: byte beats in, framing flags out.
`timescale 1ns / 1ps

import hmed_pkg::*;

typedef enum bit {MODE_REQUEST = 1'b0, MODE_RESPONSE = 1'b1} mode_e;
typedef byte unsigned bytes_t[$];

localparam logic [2:0]  MODE_REG_ADDR = 3'd0;
localparam logic [63:0] LEN_MAX       = 64'hFFFF_FFFF;

class completion_board;
  typedef enum logic [2:0] {
    PH_HEADER, PH_SKIP_SP, PH_DEC, PH_DEC_TAIL, PH_BODY, PH_HEX, PH_HEX_TAIL, PH_SKIP_LF
  } phase_e;

  mode_e       mode;
  phase_e      phase;
  int unsigned kw_pos;
  int unsigned end_pos;
  bit          line_start;
  bit          len_seen;
  bit          ovf;
  bit          done;
  logic [63:0] decl;
  logic [63:0] body;
  string       keyword = "Content-Length:";
  res_beat_t   expected_flags[$];
  int unsigned errors;
  int unsigned beats_in;
  int unsigned results_seen;
  int unsigned completions;
  int unsigned overflows;

  function new();
    mode = MODE_REQUEST;
    clear_parse();
  endfunction

  function void clear_parse();
    phase      = PH_HEADER;
    kw_pos     = 0;
    end_pos    = 0;
    line_start = 1'b1;
    len_seen   = 1'b0;
    decl       = '0;
    body       = '0;
    ovf        = 1'b0;
    done       = 1'b0;
  endfunction

  function void accumulate(int unsigned base, int unsigned digit);
    if (decl > (LEN_MAX - digit) / base) begin
      decl = LEN_MAX;
      ovf  = 1'b1;
    end else begin
      decl = decl * base + digit;
    end
  endfunction

  function int hex_val(byte unsigned b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  function bit header_end(byte unsigned b);
    string       pat;
    int unsigned pos;
    if (mode == MODE_RESPONSE) begin
      pat = "\015\n\015\n";
    end else begin
      pat = "\n\015\n";
    end
    pos = end_pos;
    if (pos >= pat.len()) pos = 0;
    if (b == pat[pos]) begin
      pos++;
      if (pos == pat.len()) begin
        end_pos = 0;
        return 1'b1;
      end
    end else begin
      pos = (b == pat[0]) ? 1 : 0;
    end
    end_pos = pos;
    return 1'b0;
  endfunction

  function void header_byte(byte unsigned b);
    bit lf;
    lf = (b == LF);
    case (phase)
      PH_HEADER: begin
        if (mode == MODE_REQUEST) begin
          if (line_start && b == keyword[0]) begin
            kw_pos = 1;
          end else if (kw_pos > 0 && kw_pos < KW_LEN && b == keyword[kw_pos]) begin
            kw_pos++;
          end else begin
            kw_pos = 0;
          end
          if (kw_pos >= KW_LEN) begin
            kw_pos   = 0;
            len_seen = 1'b1;
            decl     = '0;
            phase    = PH_SKIP_SP;
          end
        end
      end
      PH_SKIP_SP: phase = lf ? PH_HEADER : PH_DEC;
      PH_DEC: begin
        if (b >= "0" && b <= "9") begin
          accumulate(10, b - "0");
        end else begin
          phase = lf ? PH_HEADER : PH_DEC_TAIL;
        end
      end
      default: if (lf) phase = PH_HEADER;
    endcase
    line_start = lf;
    if (header_end(b)) begin
      kw_pos = 0;
      body   = '0;
      if (mode == MODE_RESPONSE) begin
        decl  = '0;
        phase = PH_HEX;
      end else begin
        phase = PH_BODY;
        if (!len_seen || decl == 0) done = 1'b1;
      end
    end
  endfunction

  function void note_input(msg_beat_t m);
    byte unsigned b;
    int           v;
    res_beat_t    want;
    b = m.data_byte;
    beats_in++;
    if (m.start_of_message) clear_parse();
    if (!done) begin
      case (phase)
        PH_BODY: begin
          body = (body + 1) & LEN_MAX;
          if (body == decl) done = 1'b1;
        end
        PH_HEX: begin
          v = hex_val(b);
          if (b == CR) begin
            phase = PH_SKIP_LF;
          end else if (v >= 0) begin
            accumulate(16, v);
          end else begin
            phase = PH_HEX_TAIL;
          end
        end
        PH_HEX_TAIL: if (b == CR) phase = PH_SKIP_LF;
        PH_SKIP_LF: begin
          phase = PH_BODY;
          body  = '0;
          if (decl == 0) done = 1'b1;
        end
        default: header_byte(b);
      endcase
    end
    want.complete        = done;
    want.in_body         = (phase >= PH_BODY);
    want.length_overflow = ovf;
    expected_flags.push_back(want);
  endfunction

  task report(string what);
    errors++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task check_result(res_beat_t got);
    res_beat_t want;
    results_seen++;
    if (got.complete) completions++;
    if (got.length_overflow) overflows++;
    if (expected_flags.size() == 0) begin
      report($sformatf("result beat %0d arrived with nothing pending", results_seen));
      return;
    end
    want = expected_flags.pop_front();
    if (got.complete != want.complete)
      report($sformatf("beat %0d complete %b, want %b", results_seen, got.complete,
                       want.complete));
    if (got.in_body != want.in_body)
      report($sformatf("beat %0d in_body %b, want %b", results_seen, got.in_body,
                       want.in_body));
    if (got.length_overflow != want.length_overflow)
      report($sformatf("beat %0d length_overflow %b, want %b", results_seen,
                       got.length_overflow, want.length_overflow));
  endtask
endclass

module http_message_end_detector_tb;
  localparam int unsigned ITEMS       = 2000;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst;
  logic        msg_valid;
  logic        msg_stall;
  msg_beat_t   msg_beat;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_beat_t   res_beat;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  completion_board board = new();
  int unsigned     cycles  = 0;
  int unsigned     rx_hold = 0;
  bit              calm_rx = 1'b0;
  bit              calm_tx;
  int unsigned     req_msgs;
  int unsigned     rsp_msgs;

  http_message_end_detector u_dut (
    .clk      (clk),
    .rst      (rst),
    .msg_valid(msg_valid),
    .msg_stall(msg_stall),
    .msg_beat (msg_beat),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_beat (res_beat),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("http_message_end_detector_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm_rx <= !calm_rx;
    if (rx_hold != 0) begin
      res_stall <= 1'b1;
      rx_hold   <= rx_hold - 1;
    end else begin
      res_stall <= 1'b0;
      if (!calm_rx) rx_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) board.check_result(res_beat);
  end

  function automatic void add(ref bytes_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void add_text(ref bytes_t q, input int unsigned n);
    repeat (n) q.push_back(8'($urandom_range(32, 126)));
  endfunction

  function automatic void add_body(ref bytes_t q, input int unsigned want);
    int unsigned k;
    k = $urandom_range(0, 3);
    if (want + k > 0) begin
      repeat (want + k - 1) q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void add_field(ref bytes_t q);
    case ($urandom_range(0, 4))
      0: add(q, "Host: ");
      1: add(q, "User-Agent: ");
      2: add(q, "Content-Type: ");
      3: begin
        add(q, "\n");
        return;
      end
      default: add(q, "Connection: ");
    endcase
    add_text(q, $urandom_range(0, 10));
    add(q, "\015\n");
  endfunction

  function automatic void add_bad_keyword(ref bytes_t q);
    case ($urandom_range(0, 4))
      0: add(q, "content-length: 5\015\n");
      1: add(q, "Content-Lengt: 5\015\n");
      2: add(q, " Content-Length: 5\015\n");
      3: add(q, "X-Content-Length: 5\015\n");
      default: add(q, "Content-Length 5\015\n");
    endcase
  endfunction

  function automatic void add_length_line(ref bytes_t q, inout int unsigned want);
    int unsigned r;
    int unsigned val;
    string       v;
    add(q, "Content-Length:");
    r = $urandom_range(0, 49);
    if (r < 4) begin
      add(q, "\n");
      want = 0;
      return;
    end
    if (r < 7) begin
      add(q, "\t");
    end else if (r < 10) begin
      add(q, "9");
    end else begin
      add(q, " ");
    end
    r = $urandom_range(0, 19);
    if (r < 12) begin
      val = $urandom_range(1, 30);
      v   = $sformatf("%0d", val);
    end else if (r == 12) begin
      val = 0;
      v   = "0";
    end else if (r == 13) begin
      val = $urandom_range(1, 9);
      v   = $sformatf("000%0d", val);
    end else if (r == 14) begin
      val = 4;
      v   = "4294967295";
    end else if (r == 15) begin
      val = 4;
      v   = "4294967296";
    end else if (r == 16) begin
      val = 2;
      v   = $sformatf("%0d%0d", $urandom_range(100000, 999999), $urandom_range(100000, 999999));
    end else if (r == 17) begin
      val = $urandom_range(1, 9);
      v   = $sformatf("%0dz%0d", val, $urandom_range(0, 9));
    end else if (r == 18) begin
      val = 0;
      v   = "";
    end else begin
      val = $urandom_range(1, 9);
      v   = $sformatf("%0d ; q=1", val);
    end
    add(q, v);
    add(q, "\015\n");
    want = val;
  endfunction

  function automatic void build_request(ref bytes_t q);
    int unsigned want;
    int unsigned r;
    want = 0;
    if ($urandom_range(0, 4) != 0) add(q, "POST /upload HTTP/1.1\015\n");
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        add_length_line(q, want);
      end else if (r == 5) begin
        add_bad_keyword(q);
      end else begin
        add_field(q);
      end
    end
    add(q, "\015\n");
    add_body(q, want);
  endfunction

  function automatic void build_response(ref bytes_t q);
    int unsigned r;
    int unsigned val;
    string       v;
    val = 0;
    add(q, "HTTP/1.1 200 OK\015\n");
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) begin
        add_length_line(q, val);
      end else begin
        add_field(q);
      end
    end
    add(q, "\015\n");
    r = $urandom_range(0, 19);
    if (r < 11) begin
      val = $urandom_range(1, 40);
      v   = $sformatf("%0h", val);
      if ($urandom_range(0, 1) != 0) v = v.toupper();
    end else if (r == 11) begin
      val = $urandom_range(1, 15);
      v   = $sformatf("00%0h", val);
    end else if (r == 12) begin
      val = 0;
      v   = "0";
    end else if (r == 13) begin
      val = 3;
      v   = "FFFFFFFF";
    end else if (r == 14) begin
      val = 3;
      v   = $sformatf("%0h%08h", $urandom_range(1, 15), $urandom());
    end else if (r == 15) begin
      val = 3;
      v   = "abcdef012";
    end else if (r == 16) begin
      val = $urandom_range(1, 15);
      v   = $sformatf("%0h;ext=1", val);
    end else if (r == 17) begin
      val = 0;
      v   = "";
    end else begin
      val = $urandom_range(1, 15);
      v   = $sformatf("%0hg", val);
    end
    add(q, v);
    add(q, "\015\n");
    add_body(q, val);
  endfunction

  function automatic void build_noise(ref bytes_t q);
    repeat ($urandom_range(1, 24)) begin
      case ($urandom_range(0, 9))
        0: q.push_back(CR);
        1: q.push_back(LF);
        default: q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  task automatic send_beat(input logic [7:0] b, input bit sof);
    int unsigned gap;
    msg_beat_t   beat;
    gap = calm_tx ? 0 : pick_gap();
    beat.data_byte        = b;
    beat.start_of_message = sof;
    if (gap != 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_beat  <= beat;
    msg_valid <= 1'b1;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    board.note_input(beat);
  endtask

  task automatic send_message(input bytes_t q, input bit sof);
    for (int i = 0; i < q.size(); i++) send_beat(q[i], sof && i == 0);
  endtask

  task automatic drain();
    msg_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_flags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MODE_REG_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input mode_e m);
    logic [31:0] rd;
    apb_access(1'b1, {31'd0, m}, rd);
    board.mode = m;
    apb_access(1'b0, 32'd0, rd);
    if (rd[0] != m) board.report($sformatf("message_mode reads %b, want %b", rd[0], m));
  endtask

  initial begin
    bytes_t      q;
    mode_e       m;
    int unsigned r;
    int unsigned n_phase;
    bit          sof;

    rst       <= 1'b1;
    msg_valid <= 1'b0;
    msg_beat  <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    calm_tx   = 1'b0;
    req_msgs  = 0;
    rsp_msgs  = 0;
    n_phase   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // extremes, bare length line ending on the skipped byte, bytes after completion
    set_mode(MODE_REQUEST);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    q = {};
    add(q, "Content-Length:\n\015\n");
    send_message(q, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat("x", 1'b0);
    drain();

    while (board.beats_in < ITEMS) begin
      if (n_phase == 0) begin
        m = MODE_RESPONSE;
      end else begin
        m = mode_e'($urandom_range(0, 1));
      end
      set_mode(m);
      calm_tx = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < $urandom_range(2, 8); k++) begin
        q = {};
        r = $urandom_range(0, 19);
        if (r < 15) begin
          if (m == MODE_RESPONSE) build_response(q); else build_request(q);
        end else if (r < 17) begin
          if (m == MODE_RESPONSE) build_request(q); else build_response(q);
        end else begin
          build_noise(q);
        end
        if ($urandom_range(0, 9) == 0) begin
          r = $urandom_range(1, q.size());
          while (q.size() > r) q.delete(q.size() - 1);
        end
        sof = !(k == 0 && $urandom_range(0, 3) == 0);
        if (m == MODE_RESPONSE) rsp_msgs++; else req_msgs++;
        send_message(q, sof);
      end
      drain();
      n_phase++;
    end
    repeat (16) @(posedge clk);

    $display("covered %0d byte beats: %0d request-mode and %0d response-mode messages, %0d modes",
             board.beats_in, req_msgs, rsp_msgs, n_phase);
    $display("checked %0d result beats: %0d flagged complete, %0d flagged length overflow",
             board.results_seen, board.completions, board.overflows);
    if (board.errors == 0) begin
      $display("http_message_end_detector_tb: done, clean");
    end else begin
      $display("http_message_end_detector_tb: done, errors");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/hmed_pkg.sv
hw/rtl/hmed_apb.sv
hw/rtl/hmed_parse.sv
hw/rtl/http_message_end_detector.sv
tb/http_message_end_detector_tb.sv
